>>> design/xbr_pkg.sv
// shared types and constants for the bounded xoshiro256** generator
package xbr_pkg;

   localparam int WORD_W     = 64;
   localparam int HALF_W     = 32;
   localparam int BOUND_W    = 31;
   localparam int DIV_STEPS  = 64;
   localparam int CNT_W      = 6;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_LO = 3;

   localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
   localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
   localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D049BB133111EB;
   localparam logic [WORD_W-1:0] SEED_RESET   = 64'd1;

   localparam logic CMD_RESEED = 1'b0;
   localparam logic CMD_DRAW   = 1'b1;

   localparam logic CSR_SEED_VALUE = 1'b0;

   localparam logic MUL_SEL_A = 1'b0;
   localparam logic MUL_SEL_B = 1'b1;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_LOAD_SEED,
      DP_SM_ADD,
      DP_MUL_LL,
      DP_MUL_LH,
      DP_MUL_HL,
      DP_MIX,
      DP_STORE_WORD,
      DP_DRAW,
      DP_SCALE,
      DP_DIV_STEP,
      DP_PUBLISH
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_SM_ADD,
      ST_MUL_LL,
      ST_MUL_LH,
      ST_MUL_HL,
      ST_MIX,
      ST_STORE,
      ST_DRAW,
      ST_SCALE,
      ST_DIV,
      ST_PUBLISH
   } ctl_state_type;

   typedef struct packed {
      dp_op_type  op;
      logic       mul_sel;
      logic [1:0] word_sel;
   } dp_cmd_type;

endpackage

>>> design/xbr_datapath.sv
// generator words, splitmix64 seeder, shared 32x32 multiplier and bit-serial modulo
module xbr_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  xbr_pkg::dp_cmd_type                 cmd,
   input  logic [xbr_pkg::BOUND_W-1:0]         req_bound,
   input  logic [xbr_pkg::WORD_W-1:0]          seed_value,
   output logic [xbr_pkg::BOUND_W-1:0]         drawn_value
);

   logic [xbr_pkg::WORD_W-1:0]  words_ff [4];
   logic [xbr_pkg::WORD_W-1:0]  words_in [4];
   logic [xbr_pkg::WORD_W-1:0]  ctr_ff, ctr_in;
   logic [xbr_pkg::WORD_W-1:0]  z_ff, z_in;
   logic [xbr_pkg::WORD_W-1:0]  acc_ff, acc_in;
   logic [xbr_pkg::WORD_W-1:0]  raw_ff, raw_in;
   logic [xbr_pkg::BOUND_W-1:0] rem_ff, rem_in;
   logic [xbr_pkg::BOUND_W-1:0] bound_ff, bound_in;
   logic [xbr_pkg::BOUND_W-1:0] out_ff, out_in;

   logic [xbr_pkg::WORD_W-1:0]  mul_k;
   logic [xbr_pkg::HALF_W-1:0]  mul_a, mul_b;
   logic [xbr_pkg::WORD_W-1:0]  mul_p;
   logic [xbr_pkg::WORD_W-1:0]  sm_sum;
   logic [xbr_pkg::WORD_W-1:0]  w1_x5;
   logic [xbr_pkg::WORD_W-1:0]  n0, n1, n2, n3;
   logic [xbr_pkg::BOUND_W:0]   partial;
   logic [xbr_pkg::BOUND_W:0]   diff;
   logic                        fits;

   assign mul_k = (cmd.mul_sel == xbr_pkg::MUL_SEL_B) ? xbr_pkg::MIX_MUL_B
                                                      : xbr_pkg::MIX_MUL_A;

   always_comb begin
      mul_a = z_ff[xbr_pkg::HALF_W-1:0];
      mul_b = mul_k[xbr_pkg::HALF_W-1:0];
      if (cmd.op == xbr_pkg::DP_MUL_LH) begin
         mul_b = mul_k[xbr_pkg::WORD_W-1:xbr_pkg::HALF_W];
      end else if (cmd.op == xbr_pkg::DP_MUL_HL) begin
         mul_a = z_ff[xbr_pkg::WORD_W-1:xbr_pkg::HALF_W];
      end
   end

   assign mul_p  = 64'(mul_a) * 64'(mul_b);
   assign sm_sum = ctr_ff + xbr_pkg::GOLDEN_GAMMA;
   assign w1_x5  = words_ff[1] + (words_ff[1] << 2);

   // xoshiro256** state update
   assign n2 = words_ff[2] ^ words_ff[0];
   assign n3 = words_ff[3] ^ words_ff[1];
   assign n1 = words_ff[1] ^ n2;
   assign n0 = words_ff[0] ^ n3;

   // restoring remainder step
   assign partial = {rem_ff, raw_ff[xbr_pkg::WORD_W-1]};
   assign fits    = (partial >= {1'b0, bound_ff});
   assign diff    = partial - {1'b0, bound_ff};

   always_comb begin
      words_in = words_ff;
      ctr_in   = ctr_ff;
      z_in     = z_ff;
      acc_in   = acc_ff;
      raw_in   = raw_ff;
      rem_in   = rem_ff;
      bound_in = bound_ff;
      out_in   = out_ff;
      unique case (cmd.op)
         xbr_pkg::DP_NOP: begin
         end
         xbr_pkg::DP_CAPTURE: begin
            bound_in = (req_bound == '0) ? xbr_pkg::BOUND_W'(1) : req_bound;
         end
         xbr_pkg::DP_LOAD_SEED: begin
            ctr_in = seed_value;
         end
         xbr_pkg::DP_SM_ADD: begin
            ctr_in = sm_sum;
            z_in   = sm_sum ^ (sm_sum >> 30);
         end
         xbr_pkg::DP_MUL_LL: begin
            acc_in = mul_p;
         end
         xbr_pkg::DP_MUL_LH, xbr_pkg::DP_MUL_HL: begin
            acc_in = acc_ff + {mul_p[xbr_pkg::HALF_W-1:0], {xbr_pkg::HALF_W{1'b0}}};
         end
         xbr_pkg::DP_MIX: begin
            z_in = acc_ff ^ (acc_ff >> 27);
         end
         xbr_pkg::DP_STORE_WORD: begin
            words_in[cmd.word_sel] = acc_ff ^ (acc_ff >> 31);
         end
         xbr_pkg::DP_DRAW: begin
            raw_in      = {w1_x5[56:0], w1_x5[63:57]};
            rem_in      = '0;
            words_in[0] = n0;
            words_in[1] = n1;
            words_in[2] = n2 ^ (words_ff[1] << 17);
            words_in[3] = {n3[18:0], n3[63:19]};
         end
         xbr_pkg::DP_SCALE: begin
            raw_in = raw_ff + (raw_ff << 3);
         end
         xbr_pkg::DP_DIV_STEP: begin
            rem_in = fits ? diff[xbr_pkg::BOUND_W-1:0] : partial[xbr_pkg::BOUND_W-1:0];
            raw_in = raw_ff << 1;
         end
         xbr_pkg::DP_PUBLISH: begin
            out_in = rem_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= '{default: '0};
         ctr_ff   <= '0;
      end else begin
         words_ff <= words_in;
         ctr_ff   <= ctr_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff     <= z_in;
      acc_ff   <= acc_in;
      raw_ff   <= raw_in;
      rem_ff   <= rem_in;
      bound_ff <= bound_in;
      out_ff   <= out_in;
   end

   assign drawn_value = out_ff;

endmodule

>>> design/xbr_controller.sv
// sequencing state machine for reseed and draw requests
module xbr_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_command,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output xbr_pkg::dp_cmd_type cmd
);

   xbr_pkg::ctl_state_type state_ff, state_in;
   logic [1:0]                idx_ff, idx_in;
   logic                      pass_ff, pass_in;
   logic [xbr_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         xbr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_command == xbr_pkg::CMD_RESEED) ? xbr_pkg::ST_SEED
                                                               : xbr_pkg::ST_DRAW;
            end
         end
         xbr_pkg::ST_SEED:   state_in = xbr_pkg::ST_SM_ADD;
         xbr_pkg::ST_SM_ADD: state_in = xbr_pkg::ST_MUL_LL;
         xbr_pkg::ST_MUL_LL: state_in = xbr_pkg::ST_MUL_LH;
         xbr_pkg::ST_MUL_LH: state_in = xbr_pkg::ST_MUL_HL;
         xbr_pkg::ST_MUL_HL: begin
            state_in = (pass_ff == xbr_pkg::MUL_SEL_A) ? xbr_pkg::ST_MIX : xbr_pkg::ST_STORE;
         end
         xbr_pkg::ST_MIX:    state_in = xbr_pkg::ST_MUL_LL;
         xbr_pkg::ST_STORE: begin
            state_in = (idx_ff == 2'd3) ? xbr_pkg::ST_IDLE : xbr_pkg::ST_SM_ADD;
         end
         xbr_pkg::ST_DRAW:   state_in = xbr_pkg::ST_SCALE;
         xbr_pkg::ST_SCALE:  state_in = xbr_pkg::ST_DIV;
         xbr_pkg::ST_DIV: begin
            if (cnt_ff == xbr_pkg::CNT_W'(xbr_pkg::DIV_STEPS - 1)) begin
               state_in = xbr_pkg::ST_PUBLISH;
            end
         end
         xbr_pkg::ST_PUBLISH: begin
            if (out_free) begin
               state_in = xbr_pkg::ST_IDLE;
            end
         end
         default: state_in = xbr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.op       = xbr_pkg::DP_NOP;
      cmd.mul_sel  = pass_ff;
      cmd.word_sel = idx_ff;
      unique case (state_ff)
         xbr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = xbr_pkg::DP_CAPTURE;
            end
         end
         xbr_pkg::ST_SEED:    cmd.op = xbr_pkg::DP_LOAD_SEED;
         xbr_pkg::ST_SM_ADD:  cmd.op = xbr_pkg::DP_SM_ADD;
         xbr_pkg::ST_MUL_LL:  cmd.op = xbr_pkg::DP_MUL_LL;
         xbr_pkg::ST_MUL_LH:  cmd.op = xbr_pkg::DP_MUL_LH;
         xbr_pkg::ST_MUL_HL:  cmd.op = xbr_pkg::DP_MUL_HL;
         xbr_pkg::ST_MIX:     cmd.op = xbr_pkg::DP_MIX;
         xbr_pkg::ST_STORE:   cmd.op = xbr_pkg::DP_STORE_WORD;
         xbr_pkg::ST_DRAW:    cmd.op = xbr_pkg::DP_DRAW;
         xbr_pkg::ST_SCALE:   cmd.op = xbr_pkg::DP_SCALE;
         xbr_pkg::ST_DIV:     cmd.op = xbr_pkg::DP_DIV_STEP;
         xbr_pkg::ST_PUBLISH: begin
            if (out_free) begin
               cmd.op = xbr_pkg::DP_PUBLISH;
            end
         end
         default: cmd.op = xbr_pkg::DP_NOP;
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      pass_in      = pass_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.op == xbr_pkg::DP_PUBLISH) begin
         rsp_valid_in = 1'b1;
      end
      if (state_ff == xbr_pkg::ST_MIX) begin
         pass_in = xbr_pkg::MUL_SEL_B;
      end
      if (state_ff == xbr_pkg::ST_STORE) begin
         pass_in = xbr_pkg::MUL_SEL_A;
         idx_in  = idx_ff + 2'd1;
      end
      if (state_ff == xbr_pkg::ST_SCALE) begin
         cnt_in = '0;
      end
      if (state_ff == xbr_pkg::ST_DIV) begin
         cnt_in = cnt_ff + xbr_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xbr_pkg::ST_IDLE;
         idx_ff       <= '0;
         pass_ff      <= xbr_pkg::MUL_SEL_A;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pass_ff      <= pass_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_idle_counters_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == xbr_pkg::ST_IDLE |-> idx_ff == 2'd0 && pass_ff == xbr_pkg::MUL_SEL_A)
      else $error("seeding counters not clear in idle");

   a_div_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == xbr_pkg::ST_SCALE |=> state_ff == xbr_pkg::ST_DIV && cnt_ff == '0)
      else $error("modulo does not start at step zero");

   a_publish_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == xbr_pkg::ST_PUBLISH && rsp_valid_ff && !rsp_ready
      |=> state_ff == xbr_pkg::ST_PUBLISH && rsp_valid_ff)
      else $error("pending result overwritten");

   a_div_exit_after_all_bits: assert property (@(posedge clock) disable iff (reset)
      state_ff == xbr_pkg::ST_DIV && state_in == xbr_pkg::ST_PUBLISH
      |-> cnt_ff == xbr_pkg::CNT_W'(xbr_pkg::DIV_STEPS - 1))
      else $error("modulo left early");

endmodule

>>> design/xoshiro_bounded_random.sv
// Bounded xoshiro256** random generator seeded through splitmix64.
// A request carries req_command and req_bound over a valid/ready channel.
// command reseed loads the seed register into the splitmix64 counter and
// fills the four generator words; it returns nothing. Each word takes an
// add, two three-step 64-bit multiplies on one shared 32x32 multiplier
// with a mix step between them, and a store.
// command draw advances the generator and returns the 64-bit output modulo
// the bound on rsp_drawn_value; a bound of zero acts as one. A draw passes
// through the draw, scale, 64-step bit-serial remainder and publish steps
// before rsp_valid rises. One request is in work at a time; req_ready is
// high only while idle.
// The result sits in an output register; a new request may be accepted
// while it waits, and a stalled receiver holds the next draw at its end.
// Reset sets the seed register to 1 and clears the generator words and
// the seeder counter; draws before any reseed return 0.
// The seed register is written over the csr_ APB port at byte address 0.
module xoshiro_bounded_random (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic [xbr_pkg::BOUND_W-1:0]        req_bound,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [xbr_pkg::BOUND_W-1:0]        rsp_drawn_value,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [xbr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [xbr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [xbr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic [xbr_pkg::WORD_W-1:0] seed_ff, seed_in;
   logic                       csr_sel_seed;
   xbr_pkg::dp_cmd_type        cmd;

   assign csr_pready   = 1'b1;
   assign csr_sel_seed = (csr_paddr[xbr_pkg::CSR_ADDR_W-1:xbr_pkg::CSR_IDX_LO]
                          == xbr_pkg::CSR_SEED_VALUE);

   always_comb begin
      seed_in = seed_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_seed) begin
         seed_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= xbr_pkg::SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   assign csr_prdata = csr_sel_seed ? seed_ff : '0;

   xbr_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd)
   );

   xbr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_bound   (req_bound),
      .seed_value  (seed_ff),
      .drawn_value (rsp_drawn_value)
   );

endmodule

>>> sim/xoshiro_bounded_random_tb.sv
// self-checking testbench for the bounded xoshiro256** generator with its own predictor
module xoshiro_bounded_random_tb;

   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 240;
   localparam int SETTLE_CYCLES  = 50;
   localparam int TAIL_CYCLES    = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam logic [xbr_pkg::CSR_ADDR_W-1:0] SEED_ADDR =
      {{(xbr_pkg::CSR_ADDR_W-1){1'b0}}, xbr_pkg::CSR_SEED_VALUE} << xbr_pkg::CSR_IDX_LO;
   localparam logic [xbr_pkg::CSR_ADDR_W-1:0] UNMAPPED_ADDR =
      {{(xbr_pkg::CSR_ADDR_W-1){1'b0}}, ~xbr_pkg::CSR_SEED_VALUE} << xbr_pkg::CSR_IDX_LO;
   localparam logic [xbr_pkg::BOUND_W-1:0] BOUND_MAX = '1;

   typedef struct packed {
      logic                        command;
      logic [xbr_pkg::BOUND_W-1:0] bound;
   } gen_request_type;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_command = xbr_pkg::CMD_DRAW;
   logic [xbr_pkg::BOUND_W-1:0]    req_bound = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [xbr_pkg::BOUND_W-1:0]    rsp_drawn_value;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [xbr_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [xbr_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [xbr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   gen_request_type             pending_reqs[$];
   logic [xbr_pkg::BOUND_W-1:0] expected_draws[$];
   int unsigned                 issued_count = 0;
   int unsigned                 accepted_count = 0;
   int unsigned                 failures = 0;
   int unsigned                 quiet_cycles = 0;
   int unsigned                 gap_left = 0;
   int unsigned                 stall_left = 0;
   bit                          quiet = 1'b0;

   logic [xbr_pkg::WORD_W-1:0]  seed_shadow = xbr_pkg::SEED_RESET;
   logic [xbr_pkg::WORD_W-1:0]  gen_word[4] = '{default: '0};
   logic [xbr_pkg::WORD_W-1:0]  seeder_count = '0;

   xoshiro_bounded_random dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [xbr_pkg::WORD_W-1:0] rotl(input logic [xbr_pkg::WORD_W-1:0] x,
                                                        input int k);
      return (x << k) | (x >> (xbr_pkg::WORD_W - k));
   endfunction

   function automatic logic [xbr_pkg::WORD_W-1:0] seeder_next();
      logic [xbr_pkg::WORD_W-1:0] z;
      seeder_count = seeder_count + xbr_pkg::GOLDEN_GAMMA;
      z = seeder_count;
      z = (z ^ (z >> 30)) * xbr_pkg::MIX_MUL_A;
      z = (z ^ (z >> 27)) * xbr_pkg::MIX_MUL_B;
      return z ^ (z >> 31);
   endfunction

   function automatic logic [xbr_pkg::WORD_W-1:0] advance_generator();
      logic [xbr_pkg::WORD_W-1:0] result;
      logic [xbr_pkg::WORD_W-1:0] shifted;
      result = rotl(gen_word[1] * 64'd5, 7) * 64'd9;
      shifted = gen_word[1] << 17;
      gen_word[2] ^= gen_word[0];
      gen_word[3] ^= gen_word[1];
      gen_word[1] ^= gen_word[2];
      gen_word[0] ^= gen_word[3];
      gen_word[2] ^= shifted;
      gen_word[3] = rotl(gen_word[3], 45);
      return result;
   endfunction

   function automatic void predict_request(input logic command,
                                           input logic [xbr_pkg::BOUND_W-1:0] bound);
      logic [xbr_pkg::WORD_W-1:0] raw;
      logic [xbr_pkg::WORD_W-1:0] divisor;
      if (command == xbr_pkg::CMD_RESEED) begin
         seeder_count = seed_shadow;
         for (int i = 0; i < 4; i++) gen_word[i] = seeder_next();
      end else begin
         divisor = (bound == '0) ? 64'd1
                                 : {{(xbr_pkg::WORD_W-xbr_pkg::BOUND_W){1'b0}}, bound};
         raw = advance_generator();
         expected_draws.push_back(xbr_pkg::BOUND_W'(raw % divisor));
      end
   endfunction

   function automatic logic [xbr_pkg::BOUND_W-1:0] random_bound();
      int unsigned bits;
      bits = $urandom_range(1, xbr_pkg::BOUND_W);
      return xbr_pkg::BOUND_W'($urandom) & xbr_pkg::BOUND_W'((64'd1 << bits) - 64'd1);
   endfunction

   task automatic queue_request(input logic command, input logic [xbr_pkg::BOUND_W-1:0] bound);
      pending_reqs.push_back('{command: command, bound: bound});
      issued_count++;
   endtask

   task automatic settle();
      do @(negedge clock);
      while (accepted_count != issued_count || expected_draws.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write a register, then read the seed register back
   task automatic write_csr(input logic [xbr_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [xbr_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      if (addr == SEED_ADDR) seed_shadow = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= SEED_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      if (csr_prdata !== seed_shadow) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $display("seed readback mismatch: expected %h, actual %h", seed_shadow, csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   always @(posedge clock) begin : drive_requests
      gen_request_type item;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_request(req_command, req_bound);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(0, 10);
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               item = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_command <= item.command;
               req_bound <= item.bound;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_responses
      logic [xbr_pkg::BOUND_W-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_draws.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("unexpected response: drawn_value %h", rsp_drawn_value);
            end else begin
               want = expected_draws.pop_front();
               if (rsp_drawn_value !== want) begin
                  failures++;
                  if (failures <= MAX_REPORTS)
                     $display("drawn_value mismatch: expected %h, actual %h",
                              want, rsp_drawn_value);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("xoshiro_bounded_random_tb failed");
            $finish;
         end
      end
   end

   initial begin
      logic [xbr_pkg::CSR_DATA_W-1:0] seed;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // all-zero state before any reseed
      queue_request(xbr_pkg::CMD_DRAW, BOUND_MAX);
      queue_request(xbr_pkg::CMD_DRAW, '0);
      queue_request(xbr_pkg::CMD_DRAW, 31'd1);
      // reset seed
      queue_request(xbr_pkg::CMD_RESEED, random_bound());
      queue_request(xbr_pkg::CMD_DRAW, 31'd1);
      queue_request(xbr_pkg::CMD_DRAW, 31'd2);
      queue_request(xbr_pkg::CMD_DRAW, 31'd3);
      queue_request(xbr_pkg::CMD_DRAW, '0);
      queue_request(xbr_pkg::CMD_DRAW, BOUND_MAX);
      queue_request(xbr_pkg::CMD_DRAW, 31'h4000_0000);
      queue_request(xbr_pkg::CMD_DRAW, 31'h5555_5555);
      queue_request(xbr_pkg::CMD_DRAW, 31'h2AAA_AAAA);
      settle();
      write_csr(SEED_ADDR, '0);
      queue_request(xbr_pkg::CMD_RESEED, BOUND_MAX);
      queue_request(xbr_pkg::CMD_DRAW, BOUND_MAX);
      queue_request(xbr_pkg::CMD_DRAW, 31'h0001_0000);
      settle();
      write_csr(SEED_ADDR, '1);
      queue_request(xbr_pkg::CMD_RESEED, '0);
      queue_request(xbr_pkg::CMD_DRAW, BOUND_MAX);
      queue_request(xbr_pkg::CMD_DRAW, random_bound());
      settle();
      // write to an unmapped register must leave the seed alone
      write_csr(UNMAPPED_ADDR, {$urandom, $urandom});
      queue_request(xbr_pkg::CMD_RESEED, random_bound());
      queue_request(xbr_pkg::CMD_DRAW, BOUND_MAX);
      queue_request(xbr_pkg::CMD_DRAW, random_bound());

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         case (p)
            1: seed = '1;
            2: seed = '0;
            default: seed = {$urandom, $urandom};
         endcase
         write_csr(SEED_ADDR, seed);
         if (p == RANDOM_PHASES - 1) quiet = 1'b1;
         if (p != 3) queue_request(xbr_pkg::CMD_RESEED, random_bound());
         for (int i = 1; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 15) == 0) queue_request(xbr_pkg::CMD_RESEED, random_bound());
            else queue_request(xbr_pkg::CMD_DRAW, random_bound());
         end
      end

      do @(negedge clock);
      while (accepted_count != issued_count || expected_draws.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("xoshiro_bounded_random_tb passed");
      end else begin
         $display("xoshiro_bounded_random_tb failed");
      end
      $finish;
   end

endmodule

>>> xoshiro_bounded_random.f
design/xbr_pkg.sv
design/xbr_datapath.sv
design/xbr_controller.sv
design/xoshiro_bounded_random.sv
sim/xoshiro_bounded_random_tb.sv
